// ===== hdl/pspm_pkg.sv =====
// Shared types and constants for the piston stroke pulse measurer.
`timescale 1ns / 1ps

package pspm_pkg;

   localparam int COUNT_WIDTH    = 30;
   localparam int ID_WIDTH       = 8;
   localparam int CSR_IDX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH = 30;

   // Result queue: two words per item at most, four entries.
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;
   localparam int QUEUE_CNT_WIDTH = 3;

   localparam logic [ID_WIDTH-1:0]    DEVICE_ID_RESET   = 8'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT_RESET = 30'd1000000000;

   // Register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEVICE_ID   = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COUNT_LIMIT = 1'b1;

   // Input word kinds.
   localparam logic [1:0] KIND_ENCODER = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_COMMAND = 2'd2;

   // Command codes.
   localparam logic [7:0] CMD_ADVANCE = 8'd1;
   localparam logic [7:0] CMD_RETRACT = 8'd2;
   localparam logic [7:0] CMD_ZERO    = 8'd3;
   localparam logic [7:0] CMD_REPORT  = 8'd4;
   localparam logic [7:0] CMD_START   = 8'd5;
   localparam logic [7:0] CMD_STOP    = 8'd6;

   // Response kinds.
   localparam logic [1:0] RSP_STATUS = 2'd0;
   localparam logic [1:0] RSP_ACK    = 2'd1;
   localparam logic [1:0] RSP_COUNT  = 2'd2;
   localparam logic [1:0] RSP_PAIR   = 2'd3;

   typedef struct packed {
      logic [1:0]          kind;
      logic [ID_WIDTH-1:0] address;
      logic [7:0]          command_code;
   } req_word_type;

   typedef struct packed {
      logic [1:0]             response_kind;
      logic [COUNT_WIDTH-1:0] first_value;
      logic [COUNT_WIDTH-1:0] second_value;
      logic                   valve_on;
      logic                   last;
   } rsp_word_type;

endpackage

// ===== hdl/piston_stroke_pulse_measurer_top.sv =====
// Top level of the piston stroke pulse measurer: state update and result queue.
`timescale 1ns / 1ps

// Result words are written into the result queue when their input word is accepted and are
// offered on the rsp_ channel in order from the queue head. The block takes one input word per
// cycle while req_stall is low; start and stop commands give two result words, and the four-entry
// result queue holds req_stall high once it has fewer than two free entries.
// Reset (synchronous, active high) returns all piston state to its idle values, empties the
// result queue and loads device_id with 1 and count_limit with 1000000000.
module piston_stroke_pulse_measurer_top
   import pspm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data
);

   // Configuration registers.
   logic [ID_WIDTH-1:0]    device_id_ff;
   logic [COUNT_WIDTH-1:0] count_limit_ff;

   // Piston state, updated in the cycle a word is accepted.
   logic [COUNT_WIDTH-1:0] pulse_count_ff,    pulse_count_in;
   logic                   moved_flag_ff,     moved_flag_in;
   logic                   is_advanced_ff,    is_advanced_in;
   logic                   routine_enabled_ff, routine_enabled_in;
   logic                   period_done_ff,    period_done_in;
   logic [COUNT_WIDTH-1:0] advance_pulses_ff, advance_pulses_in;
   logic [COUNT_WIDTH-1:0] retract_pulses_ff, retract_pulses_in;
   logic                   valve_level_ff,    valve_level_in;

   // Result words produced by the accepted input word.
   rsp_word_type           first_res;
   rsp_word_type           second_res;
   logic                   two_res;

   // Result queue.
   rsp_word_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] fill_ff,   fill_in;

   logic                   req_accept;
   logic                   rsp_accept;
   logic [COUNT_WIDTH:0]   count_plus;

   // Two free entries are needed so that any input word fits without checking its kind.
   assign req_stall  = (fill_ff > QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (fill_ff != '0);
   assign rsp_word   = queue_ff[rd_ptr_ff];
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign count_plus = {1'b0, pulse_count_ff} + (COUNT_WIDTH+1)'(1);

   // Next state and result words for the word on req_word.
   always_comb begin
      logic [1:0]             res0_kind;
      logic [COUNT_WIDTH-1:0] res0_first;
      logic [COUNT_WIDTH-1:0] res0_second;
      logic [COUNT_WIDTH-1:0] res1_first;

      pulse_count_in     = pulse_count_ff;
      moved_flag_in      = moved_flag_ff;
      is_advanced_in     = is_advanced_ff;
      routine_enabled_in = routine_enabled_ff;
      period_done_in     = period_done_ff;
      advance_pulses_in  = advance_pulses_ff;
      retract_pulses_in  = retract_pulses_ff;
      valve_level_in     = valve_level_ff;
      res0_kind          = RSP_STATUS;
      res0_first         = '0;
      res0_second        = '0;
      res1_first         = '0;
      two_res            = 1'b0;

      case (req_word.kind)
         KIND_ENCODER: begin
            // The counter wraps to zero once it would pass the limit.
            moved_flag_in = 1'b1;
            if (count_plus > {1'b0, count_limit_ff}) begin
               pulse_count_in = '0;
            end else begin
               pulse_count_in = count_plus[COUNT_WIDTH-1:0];
            end
         end
         KIND_TICK: begin
            if (routine_enabled_ff && !period_done_ff) begin
               valve_level_in = !is_advanced_ff;
               if (moved_flag_ff) begin
                  moved_flag_in = 1'b0;
               end else if (pulse_count_ff != '0) begin
                  // A quiet tick with pulses counted ends the stroke.
                  if (is_advanced_ff) begin
                     retract_pulses_in = pulse_count_ff;
                     is_advanced_in    = 1'b0;
                     period_done_in    = 1'b1;
                  end else begin
                     advance_pulses_in = pulse_count_ff;
                     is_advanced_in    = 1'b1;
                  end
                  pulse_count_in = '0;
                  moved_flag_in  = 1'b1;
               end else begin
                  moved_flag_in = 1'b1;
               end
            end
         end
         KIND_COMMAND: begin
            if (req_word.address == device_id_ff) begin
               case (req_word.command_code)
                  CMD_ADVANCE, CMD_RETRACT: begin
                     valve_level_in = (req_word.command_code == CMD_ADVANCE);
                     is_advanced_in = (req_word.command_code == CMD_ADVANCE);
                     pulse_count_in = '0;
                     res0_kind      = RSP_ACK;
                  end
                  CMD_ZERO: begin
                     pulse_count_in = '0;
                     res0_kind      = RSP_COUNT;
                  end
                  CMD_REPORT: begin
                     res0_kind      = RSP_COUNT;
                     res0_first     = pulse_count_ff;
                     pulse_count_in = '0;
                  end
                  CMD_START, CMD_STOP: begin
                     // Both retract the piston and report the count they clear.
                     valve_level_in = 1'b0;
                     is_advanced_in = 1'b0;
                     pulse_count_in = '0;
                     if (req_word.command_code == CMD_START) begin
                        routine_enabled_in = 1'b1;
                     end else begin
                        routine_enabled_in = 1'b0;
                        period_done_in     = 1'b0;
                     end
                     res0_kind  = RSP_ACK;
                     res1_first = pulse_count_ff;
                     two_res    = 1'b1;
                  end
                  default: begin
                     // Any other code reads the stroke pair once a period is complete.
                     if (routine_enabled_ff && period_done_ff) begin
                        res0_kind      = RSP_PAIR;
                        res0_first     = advance_pulses_ff;
                        res0_second    = retract_pulses_ff;
                        period_done_in = 1'b0;
                        moved_flag_in  = 1'b1;
                     end
                  end
               endcase
            end
         end
         default: begin
            // The unused kind only returns the valve status.
         end
      endcase

      first_res.response_kind  = res0_kind;
      first_res.first_value    = res0_first;
      first_res.second_value   = res0_second;
      first_res.valve_on       = valve_level_in;
      first_res.last           = !two_res;

      second_res.response_kind = RSP_COUNT;
      second_res.first_value   = res1_first;
      second_res.second_value  = '0;
      second_res.valve_on      = valve_level_in;
      second_res.last          = 1'b1;
   end

   // Queue pointers and fill level.
   always_comb begin
      logic [QUEUE_CNT_WIDTH-1:0] push_cnt;

      push_cnt  = '0;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (req_accept) begin
         push_cnt  = two_res ? QUEUE_CNT_WIDTH'(2) : QUEUE_CNT_WIDTH'(1);
         wr_ptr_in = wr_ptr_ff + push_cnt[QUEUE_PTR_WIDTH-1:0];
      end
      if (rsp_accept) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      fill_in = fill_ff + push_cnt - QUEUE_CNT_WIDTH'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff       <= DEVICE_ID_RESET;
         count_limit_ff     <= COUNT_LIMIT_RESET;
         pulse_count_ff     <= '0;
         moved_flag_ff      <= 1'b1;
         is_advanced_ff     <= 1'b0;
         routine_enabled_ff <= 1'b0;
         period_done_ff     <= 1'b0;
         advance_pulses_ff  <= '0;
         retract_pulses_ff  <= '0;
         valve_level_ff     <= 1'b0;
         wr_ptr_ff          <= '0;
         rd_ptr_ff          <= '0;
         fill_ff            <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEVICE_ID:   device_id_ff   <= csr_write_data[ID_WIDTH-1:0];
               CSR_COUNT_LIMIT: count_limit_ff <= csr_write_data[COUNT_WIDTH-1:0];
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            pulse_count_ff     <= pulse_count_in;
            moved_flag_ff      <= moved_flag_in;
            is_advanced_ff     <= is_advanced_in;
            routine_enabled_ff <= routine_enabled_in;
            period_done_ff     <= period_done_in;
            advance_pulses_ff  <= advance_pulses_in;
            retract_pulses_ff  <= retract_pulses_in;
            valve_level_ff     <= valve_level_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage; the second word of a start or stop goes into the next entry.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         queue_ff[wr_ptr_ff] <= first_res;
         if (two_res) begin
            queue_ff[wr_ptr_ff + QUEUE_PTR_WIDTH'(1)] <= second_res;
         end
      end
   end

endmodule
